// ===== src/iffp_pkg.sv =====
`timescale 1ns / 1ps
package iffp_pkg;

  localparam int STACK_DEPTH_DEF = 16;

  localparam logic [31:0] ID_FORM   = 32'h464F524D;
  localparam logic [31:0] ID_LIST   = 32'h4C495354;
  localparam logic [31:0] ID_CAT    = 32'h43415420;
  localparam logic [7:0]  PRINT_LO  = 8'h20;
  localparam logic [7:0]  PRINT_HI  = 8'h7E;
  localparam logic [31:0] CAP_RESET = 32'd64 * 32'd1024 * 32'd1024;

  localparam logic [7:0] CFG_MAX_LEN = 8'd0;
  localparam logic [7:0] CFG_EXTRA   = 8'd1;

  localparam logic [1:0] EV_NODE = 2'd0;
  localparam logic [1:0] EV_DONE = 2'd1;
  localparam logic [1:0] EV_ERR  = 2'd2;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_BAD_TAG  = 3'd1;
  localparam logic [2:0] ERR_OVER_CAP = 3'd2;
  localparam logic [2:0] ERR_PAST_END = 3'd3;
  localparam logic [2:0] ERR_SHORT    = 3'd4;
  localparam logic [2:0] ERR_NO_ROOT  = 3'd5;
  localparam logic [2:0] ERR_STACK    = 3'd6;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  code;
    logic [31:0] tag;
    logic [31:0] sub;
    logic [31:0] len;
    logic [31:0] off;
    logic [4:0]  depth;
    logic        cont;
    logic [31:0] idx;
    logic [31:0] toff;
    logic [31:0] tcnt;
  } res_t;

  typedef struct packed {
    logic push;
    logic drain;
  } q_ctrl_t;

  function automatic logic printable(input logic [31:0] t);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if (t[8*i +: 8] < PRINT_LO || t[8*i +: 8] > PRINT_HI) ok = 1'b0;
    end
    return ok;
  endfunction

endpackage

// ===== src/iffp_stack_mem.sv =====
`timescale 1ns / 1ps
module iffp_stack_mem
  import iffp_pkg::*;
#(
  parameter int DEPTH = STACK_DEPTH_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/iffp_out_queue.sv =====
`timescale 1ns / 1ps
module iffp_out_queue
  import iffp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  q_ctrl_t ctrl,
  input  res_t    item,
  output res_t    head,
  output logic    head_valid,
  output logic    head_last,
  input  logic    head_ready,
  output logic    empty
);

  res_t       e0_r, e1_r;
  logic [1:0] cnt_r;
  logic       pop;

  assign head_valid = ctrl.drain && (cnt_r != 2'd0);
  assign head_last  = (cnt_r == 2'd1);
  assign head       = e0_r;
  assign empty      = (cnt_r == 2'd0);
  assign pop        = head_valid && head_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (ctrl.push) begin
      cnt_r <= cnt_r + 2'd1;
    end else if (pop) begin
      cnt_r <= cnt_r - 2'd1;
    end
    if (ctrl.push) begin
      if (cnt_r == 2'd0) e0_r <= item;
      else e1_r <= item;
    end else if (pop) begin
      e0_r <= e1_r;
    end
  end

endmodule

// ===== src/iff_chunk_stream_parser_unit.sv =====
`timescale 1ns / 1ps
// channel   signals                           direction  content
// in        in_tvalid/in_tready/in_tdata/user  input      one buffer byte, start flag, length
// out       out_tvalid/out_tready/out_tdata    output     node, done or error events
// cfg       cfg_valid/cfg_ready/cfg_addr/data  input      register writes, always ready
//
// a byte is dropped while no buffer is open; otherwise the sequencer takes it and pops
// finished containers, reading the container end stack through its registered
// memory port.
// each byte leaves at most two results on the output.
// rst_n clears the parse state; the stack memory needs no clearing.
// a stalled output holds the sequencer; no byte is taken until all results leave.
module iff_chunk_stream_parser_unit
  import iffp_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [39:0]  in_tdata,   // data_byte, buffer_length
  input  logic         in_tuser,   // start_of_buffer
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [239:0] out_tdata,  // error_code, node_tag, node_subtype, declared_length,
                                   // node_offset, nesting_depth, is_container, node_index,
                                   // trailing_offset, trailing_count, zero fill
  output logic [1:0]   out_tuser,  // event_kind
  output logic         out_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_addr,
  input  logic [31:0]  cfg_data
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int LW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {M_IDLE, M_HEADER, M_SKIP, M_PAD, M_TRAIL} mode_t;
  typedef enum logic [2:0] {ST_IDLE, ST_CHECK, ST_TAKE, ST_AFT, ST_BPOP, ST_BLOAD,
                            ST_FIN, ST_OUT} st_t;
  typedef enum logic [1:0] {RET_CHECK, RET_TAKE, RET_FIN} ret_t;

  st_t          st_r, st_nxt;
  ret_t         ret_r, ret_nxt;
  mode_t        mode_r, mode_nxt;
  logic [7:0]   b_r, b_nxt;
  logic [31:0]  pos_r, pos_nxt;
  logic [31:0]  bsize_r, bsize_nxt;
  logic [31:0]  hs_r [3];
  logic [31:0]  hs_nxt [3];
  logic [3:0]   hc_r, hc_nxt;
  logic [LW-1:0] level_r, level_nxt;
  logic [31:0]  tos_r, tos_nxt;
  logic [31:0]  leaf_r, leaf_nxt;
  logic         pad_r, pad_nxt;
  logic         root_r, root_nxt;
  logic [31:0]  nc_r, nc_nxt;
  logic [31:0]  tstart_r, tstart_nxt;
  logic [31:0]  bs_r, bs_nxt;
  logic [31:0]  bp_r, bp_nxt;
  logic [31:0]  mbl_r;
  logic         ext_r;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [31:0]   mem_wdata, mem_rdata;
  q_ctrl_t       qc;
  res_t          q_item, q_head;
  logic          q_empty, q_last;

  iffp_stack_mem #(.DEPTH(STACK_DEPTH), .AW(AW)) u_stack (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .re(mem_re), .raddr(mem_raddr), .rdata(mem_rdata)
  );

  iffp_out_queue u_queue (
    .clk(clk), .rst_n(rst_n), .ctrl(qc), .item(q_item), .head(q_head),
    .head_valid(out_tvalid), .head_last(q_last), .head_ready(out_tready),
    .empty(q_empty)
  );

  assign in_tready = (st_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_tlast = q_last;
  assign out_tuser = q_head.kind;
  assign out_tdata = {7'd0, q_head.tcnt, q_head.toff, q_head.idx, q_head.cont,
                      q_head.depth, q_head.off, q_head.len, q_head.sub, q_head.tag,
                      q_head.code};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mbl_r <= CAP_RESET;
      ext_r <= 1'b1;
    end else if (cfg_valid) begin
      if (cfg_addr == CFG_MAX_LEN) mbl_r <= cfg_data;
      else if (cfg_addr == CFG_EXTRA) ext_r <= cfg_data[0];
    end
  end

  always_comb begin
    logic [1:0]  k;
    logic [3:0]  c;
    logic [31:0] tag, len, sub, pos1;
    logic        nested, cont;
    logic [33:0] end64;
    logic [LW-1:0] lvl_m2;
    st_nxt = st_r; ret_nxt = ret_r; mode_nxt = mode_r; b_nxt = b_r; pos_nxt = pos_r;
    bsize_nxt = bsize_r; hs_nxt = hs_r; hc_nxt = hc_r; level_nxt = level_r;
    tos_nxt = tos_r; leaf_nxt = leaf_r; pad_nxt = pad_r; root_nxt = root_r;
    nc_nxt = nc_r; tstart_nxt = tstart_r; bs_nxt = bs_r; bp_nxt = bp_r;
    mem_we = 1'b0; mem_re = 1'b0; mem_waddr = '0; mem_raddr = '0; mem_wdata = '0;
    qc = '0; q_item = '0;
    k = (hc_r[3:2] > 2'd2) ? 2'd2 : hc_r[3:2];
    tag = (k == 2'd0) ? {hs_r[0][23:0], b_r} : hs_r[0];
    len = (k == 2'd1) ? {hs_r[1][23:0], b_r} : hs_r[1];
    sub = (k == 2'd2) ? {hs_r[2][23:0], b_r} : hs_r[2];
    c = hc_r + 4'd1;
    pos1 = pos_r + 32'd1;
    nested = (level_r != '0);
    cont = (tag == ID_FORM) || (ext_r && (tag == ID_LIST || tag == ID_CAT));
    end64 = {2'b0, bs_r} + 34'd8 + {2'b0, len};
    lvl_m2 = level_r - LW'(2);
    unique case (st_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          b_nxt = in_tdata[7:0];
          if (in_tuser) begin
            pos_nxt = '0; mode_nxt = M_IDLE; hs_nxt[0] = '0; hs_nxt[1] = '0;
            hs_nxt[2] = '0; hc_nxt = '0; level_nxt = '0; leaf_nxt = '0; pad_nxt = 1'b0;
            root_nxt = 1'b0; nc_nxt = '0; tstart_nxt = '0; bs_nxt = '0;
            bsize_nxt = in_tdata[39:8];
            if (in_tdata[39:8] == 32'd0) begin
              qc.push = 1'b1; q_item.kind = EV_ERR; q_item.code = ERR_NO_ROOT;
              st_nxt = ST_OUT;
            end else begin
              bp_nxt = '0; ret_nxt = RET_CHECK; st_nxt = ST_BPOP;
            end
          end else begin
            st_nxt = ST_CHECK;
          end
        end
      end
      ST_CHECK: st_nxt = (mode_r == M_IDLE) ? ST_IDLE : ST_TAKE;
      ST_TAKE: begin
        st_nxt = ST_FIN;
        case (mode_r)
          M_HEADER: begin
            hs_nxt[k] = {hs_r[k][23:0], b_r};
            hc_nxt = c;
            if (c == 4'd4 && !nested && !printable(tag)) begin
              mode_nxt = M_TRAIL; tstart_nxt = bs_r;
            end else if (c == 4'd8) begin
              q_item.kind = EV_ERR; q_item.off = bs_r;
              if (nested && end64 > {2'b0, tos_r}) begin
                leaf_nxt = tos_r; pad_nxt = 1'b0;
                if (pos1 >= tos_r) begin
                  bp_nxt = pos1; st_nxt = ST_AFT;
                end else mode_nxt = M_SKIP;
              end else if (nested && !printable(tag)) q_item.code = ERR_BAD_TAG;
              else if (len > mbl_r) q_item.code = ERR_OVER_CAP;
              else if (!nested && end64 > {2'b0, bsize_r}) q_item.code = ERR_PAST_END;
              else if (cont) begin
                if (len < 32'd4) q_item.code = ERR_SHORT;
              end else begin
                qc.push = 1'b1; q_item.kind = EV_NODE; q_item.tag = tag;
                q_item.len = len; q_item.depth = 5'(level_r); q_item.idx = nc_r;
                nc_nxt = nc_r + 32'd1;
                if (!nested) root_nxt = 1'b1;
                leaf_nxt = end64[31:0]; pad_nxt = nested & len[0];
                if (pos1 >= end64[31:0]) begin
                  bp_nxt = pos1; st_nxt = ST_AFT;
                end else mode_nxt = M_SKIP;
              end
              if (q_item.code != ERR_NONE) begin
                qc.push = 1'b1; mode_nxt = M_IDLE; st_nxt = ST_OUT;
              end
            end else if (c >= 4'd12) begin
              q_item.off = bs_r;
              if (!printable(sub) || level_r >= LW'(STACK_DEPTH)) begin
                qc.push = 1'b1; q_item.kind = EV_ERR;
                q_item.code = !printable(sub) ? ERR_BAD_TAG : ERR_STACK;
                mode_nxt = M_IDLE; st_nxt = ST_OUT;
              end else begin
                qc.push = 1'b1; q_item.kind = EV_NODE; q_item.tag = tag; q_item.sub = sub;
                q_item.len = len; q_item.depth = 5'(level_r); q_item.cont = 1'b1;
                q_item.idx = nc_r; nc_nxt = nc_r + 32'd1;
                if (!nested) root_nxt = 1'b1;
                mem_we = 1'b1; mem_waddr = level_r[AW-1:0]; mem_wdata = end64[31:0];
                tos_nxt = end64[31:0]; level_nxt = level_r + LW'(1);
                bp_nxt = pos1; ret_nxt = RET_FIN; st_nxt = ST_BPOP;
              end
            end
          end
          M_SKIP: begin
            if (pos1 >= leaf_r) begin
              bp_nxt = pos1; st_nxt = ST_AFT;
            end
          end
          M_PAD: begin
            pad_nxt = 1'b0; st_nxt = ST_BPOP;
            if (b_r == 8'd0) begin
              bp_nxt = pos1; ret_nxt = RET_FIN;
            end else begin
              bp_nxt = pos_r; ret_nxt = RET_TAKE;
            end
          end
          default: ;
        endcase
      end
      ST_AFT: begin
        if (pad_r && nested && tos_r > bp_r) begin
          mode_nxt = M_PAD; st_nxt = ST_FIN;
        end else begin
          pad_nxt = 1'b0; ret_nxt = RET_FIN; st_nxt = ST_BPOP;
        end
      end
      ST_BPOP: begin
        if (nested && tos_r <= bp_r) begin
          level_nxt = level_r - LW'(1);
          if (level_r > LW'(1)) begin
            mem_re = 1'b1; mem_raddr = lvl_m2[AW-1:0]; st_nxt = ST_BLOAD;
          end
        end else begin
          unique case (ret_r)
            RET_CHECK: st_nxt = ST_CHECK;
            RET_TAKE:  st_nxt = ST_TAKE;
            default:   st_nxt = ST_FIN;
          endcase
          if (!nested && bp_r >= bsize_r) mode_nxt = M_IDLE;
          else if (!nested && (bsize_r - bp_r) < 32'd8) begin
            mode_nxt = M_TRAIL; tstart_nxt = bp_r;
          end else if (nested && (tos_r - bp_r) < 32'd8) begin
            mode_nxt = M_SKIP; leaf_nxt = tos_r; pad_nxt = 1'b0;
          end else begin
            mode_nxt = M_HEADER; bs_nxt = bp_r; hc_nxt = '0;
            hs_nxt[0] = '0; hs_nxt[1] = '0; hs_nxt[2] = '0;
          end
        end
      end
      ST_BLOAD: begin
        tos_nxt = mem_rdata; st_nxt = ST_BPOP;
      end
      ST_FIN: begin
        pos_nxt = pos1; st_nxt = ST_OUT;
        if (pos1 >= bsize_r) begin
          qc.push = 1'b1; mode_nxt = M_IDLE;
          if (!root_r) begin
            q_item.kind = EV_ERR; q_item.code = ERR_NO_ROOT;
          end else begin
            q_item.kind = EV_DONE;
            if (mode_r == M_TRAIL) begin
              q_item.toff = tstart_r; q_item.tcnt = bsize_r - tstart_r;
            end
          end
        end
      end
      ST_OUT: begin
        qc.drain = 1'b1;
        if (q_empty || (out_tready && q_last)) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; ret_r <= RET_CHECK; mode_r <= M_IDLE; pos_r <= '0;
      bsize_r <= '0; hc_r <= '0; level_r <= '0; leaf_r <= '0; pad_r <= 1'b0;
      root_r <= 1'b0; nc_r <= '0; tstart_r <= '0; bs_r <= '0; bp_r <= '0;
      tos_r <= '0; b_r <= '0;
      hs_r[0] <= '0; hs_r[1] <= '0; hs_r[2] <= '0;
    end else begin
      st_r <= st_nxt; ret_r <= ret_nxt; mode_r <= mode_nxt; pos_r <= pos_nxt;
      bsize_r <= bsize_nxt; hc_r <= hc_nxt; level_r <= level_nxt; leaf_r <= leaf_nxt;
      pad_r <= pad_nxt; root_r <= root_nxt; nc_r <= nc_nxt; tstart_r <= tstart_nxt;
      bs_r <= bs_nxt; bp_r <= bp_nxt; tos_r <= tos_nxt; b_r <= b_nxt;
      hs_r <= hs_nxt;
    end
  end

endmodule
